/* rtl/chunked_marker_framer_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the chunked marker framer
// Shared property forms used by the top level checks.
// ---------------------------------------------------------------------------
`ifndef CHUNKED_MARKER_FRAMER_TOP_DEFINES_SVH
`define CHUNKED_MARKER_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CMF_ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, disabled during reset.
`define CMF_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

/* rtl/cmf_pkg.sv */
// ---------------------------------------------------------------------------
// cmf_pkg
// Types and constants shared by the chunked marker framer modules.
// ---------------------------------------------------------------------------
package cmf_pkg;

  // Open chunk kinds.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ENDS   = 2'd1;
  localparam logic [1:0] KIND_FIRST  = 2'd2;
  localparam logic [1:0] KIND_MIDDLE = 2'd3;

  // Marker placed before the data byte.
  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_BEG   = 2'd1;
  localparam logic [1:0] PRE_TILDE = 2'd2;

  // Marker placed after the data byte.
  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_END   = 2'd1;
  localparam logic [1:0] POST_TILDE = 2'd2;

  localparam logic [7:0] TILDE_CHAR = 8'h7E;
  localparam logic [7:0] BEG_MARK [0:4] = '{8'h3C, 8'h42, 8'h45, 8'h47, 8'h3E};
  localparam logic [7:0] END_MARK [0:4] = '{8'h3C, 8'h45, 8'h4E, 8'h44, 8'h3E};

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One classified request: the data byte and the markers around it.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] pre;
    logic [1:0] post;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* rtl/cmf_front.sv */
// ---------------------------------------------------------------------------
// cmf_front
// Accepts message bytes, tracks message position and chunk state, and
// decides which markers surround each byte.
// ---------------------------------------------------------------------------
module cmf_front #(
  parameter int SINGLE_MAX = 54,
  parameter int FIRST_MAX  = 58,
  parameter int MIDDLE_MAX = 62,
  parameter int LAST_MAX   = 58
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    message_length,
  output cmf_pkg::item_t item
);
  import cmf_pkg::*;

  localparam logic [8:0] SINGLE_LIM = 9'(SINGLE_MAX);
  localparam logic [8:0] LAST_LIM   = 9'(LAST_MAX);
  localparam logic [5:0] FIRST_CAP  = 6'((FIRST_MAX > 63) ? 63 : FIRST_MAX);
  localparam logic [5:0] MIDDLE_CAP = 6'((MIDDLE_MAX > 63) ? 63 : MIDDLE_MAX);

  logic [7:0] byte_position, byte_position_next;
  logic [5:0] chunk_bytes_left, chunk_bytes_left_next;
  logic [1:0] chunk_kind, chunk_kind_next;

  logic [7:0] len, len_m1, remaining, rem_m1;
  logic [8:0] pos_inc;
  logic [5:0] cnt_open, cnt_dec;
  logic [1:0] kind_open;

  always_comb begin
    len       = (message_length == 8'd0) ? 8'd1 : message_length;
    len_m1    = len - 8'd1;
    remaining = (byte_position < len) ? (len - byte_position) : 8'd1;
    rem_m1    = remaining - 8'd1;
    pos_inc   = {1'b0, byte_position} + 9'd1;

    item.data = data_byte;
    item.pre  = PRE_NONE;
    item.post = POST_NONE;
    kind_open = chunk_kind;
    cnt_open  = chunk_bytes_left;

    if (chunk_kind == KIND_NONE) begin
      if (byte_position == 8'd0) begin
        item.pre = PRE_BEG;
        if ({1'b0, len} <= SINGLE_LIM) begin
          kind_open = KIND_ENDS;
        end else begin
          kind_open = KIND_FIRST;
          cnt_open  = (len_m1 < {2'b00, FIRST_CAP}) ? len_m1[5:0] : FIRST_CAP;
        end
      end else begin
        item.pre = PRE_TILDE;
        if ({1'b0, remaining} <= LAST_LIM) begin
          kind_open = KIND_ENDS;
        end else begin
          kind_open = KIND_MIDDLE;
          cnt_open  = (rem_m1 < {2'b00, MIDDLE_CAP}) ? rem_m1[5:0] : MIDDLE_CAP;
        end
      end
    end

    cnt_dec = (cnt_open != 6'd0) ? (cnt_open - 6'd1) : 6'd0;

    byte_position_next    = pos_inc[7:0];
    chunk_bytes_left_next = cnt_open;
    chunk_kind_next       = kind_open;

    if (pos_inc >= {1'b0, len}) begin
      item.post             = POST_END;
      byte_position_next    = 8'd0;
      chunk_bytes_left_next = 6'd0;
      chunk_kind_next       = KIND_NONE;
    end else if (kind_open == KIND_FIRST || kind_open == KIND_MIDDLE) begin
      chunk_bytes_left_next = cnt_dec;
      if (cnt_dec == 6'd0) begin
        item.post       = POST_TILDE;
        chunk_kind_next = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 8'd0;
      chunk_bytes_left <= 6'd0;
      chunk_kind       <= KIND_NONE;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      chunk_bytes_left <= chunk_bytes_left_next;
      chunk_kind       <= chunk_kind_next;
    end
  end

endmodule

/* rtl/cmf_queue.sv */
// ---------------------------------------------------------------------------
// cmf_queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ---------------------------------------------------------------------------
module cmf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cmf_pkg::item_t     push_item,
  input  logic               pop,
  output cmf_pkg::item_t     head,
  output cmf_pkg::q_status_t status
);
  import cmf_pkg::*;

  item_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW:0]     count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == (Q_AW + 1)'(0));
  assign status.full  = (count == (Q_AW + 1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW + 1)'(1);
      end
    end
  end

endmodule

/* rtl/cmf_back.sv */
// ---------------------------------------------------------------------------
// cmf_back
// Expands each classified request into its framed bytes, one per cycle while
// frame_stall does not hold the output, through a registered output stage.
// ---------------------------------------------------------------------------
module cmf_back (
  input  logic               clk,
  input  logic               rst,
  input  cmf_pkg::item_t     head,
  input  cmf_pkg::q_status_t q_status,
  output logic               pop,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               message_done
);
  import cmf_pkg::*;

  // Step 0 to 4 covers an opening marker, step 5 the data byte, and
  // step 6 to 10 a closing marker.
  localparam logic [3:0] STEP_TILDE_PRE = 4'd4;
  localparam logic [3:0] STEP_DATA      = 4'd5;
  localparam logic [3:0] STEP_POST      = 4'd6;
  localparam logic [3:0] STEP_END_LAST  = 4'd10;

  item_t      cur;
  logic       cur_valid;
  logic [3:0] step;

  logic [7:0] cur_byte;
  logic [3:0] last_step, first_step;
  logic [3:0] post_idx;
  logic       advance, at_last;

  always_comb begin
    post_idx = step - STEP_POST;
    if (step < STEP_DATA) begin
      cur_byte = (cur.pre == PRE_BEG) ? BEG_MARK[step[2:0]] : TILDE_CHAR;
    end else if (step == STEP_DATA) begin
      cur_byte = cur.data;
    end else begin
      cur_byte = (cur.post == POST_END) ? END_MARK[post_idx[2:0]] : TILDE_CHAR;
    end

    unique case (cur.post)
      POST_NONE:  last_step = STEP_DATA;
      POST_TILDE: last_step = STEP_POST;
      default:    last_step = STEP_END_LAST;
    endcase

    unique case (head.pre)
      PRE_NONE:  first_step = STEP_DATA;
      PRE_TILDE: first_step = STEP_TILDE_PRE;
      default:   first_step = 4'd0;
    endcase
  end

  assign advance = cur_valid && (!frame_valid || !frame_stall);
  assign at_last = (step == last_step);
  assign pop     = (!cur_valid || (advance && at_last)) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 4'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= first_step;
    end else if (advance && at_last) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte     <= cur_byte;
      run_last     <= at_last;
      message_done <= at_last && (cur.post == POST_END);
    end
  end

endmodule

/* rtl/chunked_marker_framer_top.sv */
// ---------------------------------------------------------------------------
// chunked_marker_framer_top
// Frames message bytes with <BEG>, ~ and <END> markers for a link that
// sends 64-byte chunks.
// ---------------------------------------------------------------------------
// Channel   Valid        Stall        Payload
// message   msg_valid    msg_stall    data_byte, message_length
// frame     frame_valid  frame_stall  out_byte, run_last, message_done
//
// A message byte is classified as it is accepted and queued, and the queue
// takes a request every cycle while it has room.
// The output sequencer sends one framed byte per cycle while frame_stall is low,
// so a request yields 1 to 11 bytes: the data byte plus one per marker byte around it.
// Synchronous reset clears chunk state, the queue pointers and the output valid flags.
// A frame stall holds the output register; the queue fills, then msg_stall rises.
`include "chunked_marker_framer_top_defines.svh"

module chunked_marker_framer_top #(
  parameter int SINGLE_MAX = 54,
  parameter int FIRST_MAX  = 58,
  parameter int MIDDLE_MAX = 62,
  parameter int LAST_MAX   = 58
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_stall,
  input  logic [7:0] data_byte,
  input  logic [7:0] message_length,
  output logic       frame_valid,
  input  logic       frame_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_done
);
  import cmf_pkg::*;

  item_t     front_item;
  item_t     head;
  q_status_t q_status;
  logic      accept;
  logic      pop;

  assign msg_stall = q_status.full;
  assign accept    = msg_valid && !q_status.full;

  cmf_front #(
    .SINGLE_MAX (SINGLE_MAX),
    .FIRST_MAX  (FIRST_MAX),
    .MIDDLE_MAX (MIDDLE_MAX),
    .LAST_MAX   (LAST_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .message_length (message_length),
    .item           (front_item)
  );

  cmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  cmf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_done (message_done)
  );

  `CMF_ASSERT_IMPLIES(a_done_is_last, clk, rst, frame_valid && message_done, run_last)
  `CMF_ASSERT_IMPLIES(a_done_on_gt, clk, rst, frame_valid && message_done, out_byte == END_MARK[4])
  `CMF_ASSERT_IMPLIES(a_queue_sane, clk, rst, q_status.full, !q_status.empty && !pop || !q_status.empty)
  `CMF_ASSERT_NEXT(a_pop_fills, clk, rst, pop, !q_status.full)

endmodule
